// ===== hw/rtl/sers_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sers_pkg
// Shared types and constants of the shadow edge row scanner.
// -----------------------------------------------------------------------------
package sers_pkg;

  localparam int MAX_SIZE   = 4096;
  localparam int CNT_W      = $clog2(MAX_SIZE);
  localparam int COORD_W    = 12;
  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int SPACING_W  = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING    = 1'd1;

  localparam logic [THR_W-1:0]     THRESHOLD_RESET = 8'd150;
  localparam logic [SPACING_W-1:0] SPACING_RESET   = 12'd10;

  // Classified pixel handed from the hit stage to the row tracker.
  typedef struct packed {
    logic hit;
    logic row_end;
    logic frame_start;
  } pix_class_t;

  // First and last hit columns of a row that qualified, with its row number.
  typedef struct packed {
    logic [COORD_W-1:0] first_col;
    logic [COORD_W-1:0] last_col;
    logic [COORD_W-1:0] row;
  } edge_pair_t;

  // Gray value (11r + 16g + 5b) / 32, rounded down.
  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [PIX_W+4:0] sum;
    sum = (PIX_W+5)'(r) * (PIX_W+5)'(11) + ((PIX_W+5)'(g) << 4)
        + (PIX_W+5)'(b) * (PIX_W+5)'(5);
    return sum[PIX_W+4:5];
  endfunction

endpackage

// ===== hw/rtl/sers_hit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sers_hit
// Input register and hit classification of each pixel pair.
// -----------------------------------------------------------------------------
module sers_hit import sers_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_take,
  input  logic [PIX_W-1:0] a_red,
  input  logic [PIX_W-1:0] a_green,
  input  logic [PIX_W-1:0] a_blue,
  input  logic [PIX_W-1:0] b_red,
  input  logic [PIX_W-1:0] b_green,
  input  logic [PIX_W-1:0] b_blue,
  input  logic             row_end,
  input  logic             frame_start,
  input  logic [THR_W-1:0] threshold,
  output logic             cls_valid,
  output pix_class_t       cls
);

  logic             s1_valid;
  logic [PIX_W-1:0] s1_ar, s1_ag, s1_ab, s1_br, s1_bg, s1_bb;
  logic             s1_row_end, s1_frame_start;

  logic [PIX_W-1:0] gray_a, gray_b, gray_max, diff;

  always_comb begin
    gray_a   = gray_of(s1_ar, s1_ag, s1_ab);
    gray_b   = gray_of(s1_br, s1_bg, s1_bb);
    gray_max = (gray_a > gray_b) ? gray_a : gray_b;
    diff     = (gray_max >= s1_ar) ? (gray_max - s1_ar) : (s1_ar - gray_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      cls_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_take;
      cls_valid <= s1_valid;
    end
    if (adv) begin
      s1_ar          <= a_red;
      s1_ag          <= a_green;
      s1_ab          <= a_blue;
      s1_br          <= b_red;
      s1_bg          <= b_green;
      s1_bb          <= b_blue;
      s1_row_end     <= row_end;
      s1_frame_start <= frame_start;
      cls.hit         <= (diff >= threshold);
      cls.row_end     <= s1_row_end;
      cls.frame_start <= s1_frame_start;
    end
  end

endmodule

// ===== hw/rtl/sers_track.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sers_track
// Row and column counters and the per-row record of first and last hits.
// -----------------------------------------------------------------------------
module sers_track import sers_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  pix_class_t           cls,
  input  logic [SPACING_W-1:0] spacing,
  output logic                 emit,
  output edge_pair_t           pair
);

  logic [CNT_W-1:0] column_count, row_count, first_hit, last_hit;
  logic [1:0]       hit_tally;

  logic [CNT_W-1:0] col_e, row_e, first_next, last_next, span;
  logic [CNT_W-1:0] column_count_next, row_count_next;
  logic [1:0]       tally_e, hit_tally_next;

  function automatic logic [CNT_W-1:0] wrap_next(input logic [CNT_W-1:0] v);
    return (v == CNT_W'(MAX_SIZE - 1)) ? '0 : v + 1'b1;
  endfunction

  always_comb begin
    // A frame start clears the counters before the pixel is counted.
    col_e   = cls.frame_start ? '0 : column_count;
    row_e   = cls.frame_start ? '0 : row_count;
    tally_e = cls.frame_start ? 2'd0 : hit_tally;

    first_next     = (cls.hit && tally_e == 2'd0) ? col_e : first_hit;
    last_next      = cls.hit ? col_e : last_hit;
    hit_tally_next = (cls.hit && tally_e != 2'd2) ? tally_e + 2'd1 : tally_e;

    span = (last_next >= first_next) ? (last_next - first_next)
                                     : (first_next - last_next);
    emit = cls.row_end && (hit_tally_next == 2'd2)
        && ((CNT_W + SPACING_W)'(span) >= (CNT_W + SPACING_W)'(spacing));

    pair.first_col = COORD_W'(first_next);
    pair.last_col  = COORD_W'(last_next);
    pair.row       = COORD_W'(row_e);

    if (cls.row_end) begin
      column_count_next = '0;
      row_count_next    = wrap_next(row_e);
    end else begin
      column_count_next = wrap_next(col_e);
      row_count_next    = row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      first_hit    <= '0;
      last_hit     <= '0;
      hit_tally    <= 2'd0;
    end else if (take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      first_hit    <= first_next;
      last_hit     <= last_next;
      hit_tally    <= cls.row_end ? 2'd0 : hit_tally_next;
    end
  end

endmodule

// ===== hw/rtl/sers_out.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sers_out
// Result register holding one edge pair, sent as two beats.
// -----------------------------------------------------------------------------
module sers_out import sers_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  edge_pair_t         pair_in,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               free,
  output logic [COORD_W-1:0] edge_column,
  output logic [COORD_W-1:0] edge_row,
  output logic               edge_side,
  output logic               last
);

  logic       full, phase;
  edge_pair_t pair;

  // The buffer empties at the beat that carries the last hit.
  assign free        = full && !out_stall && phase;
  assign out_valid   = full;
  assign edge_side   = phase;
  assign last        = phase;
  assign edge_column = phase ? pair.last_col : pair.first_col;
  assign edge_row    = pair.row;

  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      full  <= 1'b1;
      phase <= 1'b0;
    end else if (full && !out_stall) begin
      full  <= !phase;
      phase <= !phase;
    end
    if (load) begin
      pair <= pair_in;
    end
  end

endmodule

// ===== hw/rtl/shadow_edge_row_scanner.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// shadow_edge_row_scanner
// Finds the first and last shadow edge columns of each qualifying row of a pixel stream.
// -----------------------------------------------------------------------------
// Order: the row-end pixel passes the input and classify registers, then the
// pair is offered from the result register, first beat, then the last-hit beat.
// Throughput: one pixel per cycle; the two result beats of a row share one
// pair register, so the input stalls only while a row-end pixel in the
// classify stage meets an earlier pair that is still unsent.
// Reset: synchronous; counters and hit record clear, registers take defaults.
module shadow_edge_row_scanner import sers_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      a_red,
  input  logic [PIX_W-1:0]      a_green,
  input  logic [PIX_W-1:0]      a_blue,
  input  logic [PIX_W-1:0]      b_red,
  input  logic [PIX_W-1:0]      b_green,
  input  logic [PIX_W-1:0]      b_blue,
  input  logic                  row_end,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_W-1:0]    edge_column,
  output logic [COORD_W-1:0]    edge_row,
  output logic                  edge_side,
  output logic                  last
);

  logic [THR_W-1:0]     threshold;
  logic [SPACING_W-1:0] spacing;

  logic       adv, cls_valid, take, emit, free;
  pix_class_t cls;
  edge_pair_t pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      spacing   <= SPACING_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIFF_THRESHOLD: threshold <= cfg_data[THR_W-1:0];
        REG_MIN_SPACING:    spacing   <= cfg_data[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline holds only when a row end meets a pair still unsent.
  assign adv      = !(cls_valid && cls.row_end && out_valid && !free);
  assign in_stall = !adv;
  assign take     = adv && cls_valid;

  sers_hit u_hit (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_take     (in_valid),
    .a_red       (a_red),
    .a_green     (a_green),
    .a_blue      (a_blue),
    .b_red       (b_red),
    .b_green     (b_green),
    .b_blue      (b_blue),
    .row_end     (row_end),
    .frame_start (frame_start),
    .threshold   (threshold),
    .cls_valid   (cls_valid),
    .cls         (cls)
  );

  sers_track u_track (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .cls     (cls),
    .spacing (spacing),
    .emit    (emit),
    .pair    (pair)
  );

  sers_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (take && emit),
    .pair_in     (pair),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .free        (free),
    .edge_column (edge_column),
    .edge_row    (edge_row),
    .edge_side   (edge_side),
    .last        (last)
  );

  a_first_then_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !edge_side |=> out_valid && edge_side)
    else $error("first-hit beat not followed by last-hit beat");

  a_pair_row_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !edge_side |=> $stable(edge_row))
    else $error("row changed within an edge pair");

  a_new_pair_starts_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && edge_side |=> !out_valid || !edge_side)
    else $error("pair did not restart at first-hit beat");

  a_stall_needs_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && cls_valid && cls.row_end)
    else $error("input stalled without a pending pair");

endmodule

// ===== tb/sv/tb_shadow_edge_row_scanner.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_shadow_edge_row_scanner
// Self-checking bench for the shadow edge row scanner. A short table of
// directed pixels is followed by random rows under changing thresholds and
// idle patterns, with stray frame starts, early row ends and one long output
// hold-off. Every edge beat is compared with an expected beat, predicted or typed.
// -----------------------------------------------------------------------------
module tb_shadow_edge_row_scanner;
  import sers_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] ar;
    logic [PIX_W-1:0] ag;
    logic [PIX_W-1:0] ab;
    logic [PIX_W-1:0] br;
    logic [PIX_W-1:0] bg;
    logic [PIX_W-1:0] bb;
    logic             row_end;
    logic             frame_start;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               side;
    logic               is_last;
  } edge_beat_t;

  // How the edge pair of a pixel is expected: from the predictor, or typed in.
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NO_PAIR,
    CHK_PAIR
  } check_kind_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    pixel_t                pix;
    check_kind_t           check;
    logic [COORD_W-1:0]    first;
    logic [COORD_W-1:0]    fin;
    logic [COORD_W-1:0]    row;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      a_red;
  logic [PIX_W-1:0]      a_green;
  logic [PIX_W-1:0]      a_blue;
  logic [PIX_W-1:0]      b_red;
  logic [PIX_W-1:0]      b_green;
  logic [PIX_W-1:0]      b_blue;
  logic                  row_end;
  logic                  frame_start;
  logic                  out_valid;
  logic                  out_stall;
  logic [COORD_W-1:0]    edge_column;
  logic [COORD_W-1:0]    edge_row;
  logic                  edge_side;
  logic                  last;

  // Check tag travelling with the pixel on the bus.
  check_kind_t        beat_check;
  logic [COORD_W-1:0] typed_first;
  logic [COORD_W-1:0] typed_last;
  logic [COORD_W-1:0] typed_row;

  // Local copy of the scanner state and registers.
  logic [THR_W-1:0]     thr_reg;
  logic [SPACING_W-1:0] spacing_reg;
  logic [CNT_W-1:0]     col_pos = '0;
  logic [CNT_W-1:0]     row_pos = '0;
  logic [CNT_W-1:0]     first_col = '0;
  logic [CNT_W-1:0]     last_col = '0;
  logic [1:0]           hits = '0;

  edge_beat_t pending_edges[$];
  stim_row_t  directed[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_asks;
  int failures = 0;
  int pixels_taken = 0;
  int edge_beats_seen = 0;

  shadow_edge_row_scanner i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic pixel_t mk_pix(input logic [7:0] ar, ag, ab, br, bg, bb,
                                    input logic re, fs);
    pixel_t p;
    p = '{ar, ag, ab, br, bg, bb, re, fs};
    return p;
  endfunction

  function automatic stim_row_t pix_row(input pixel_t p, input check_kind_t k,
                                        input logic [COORD_W-1:0] f, l, r);
    stim_row_t s;
    s.is_cfg  = 1'b0;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.pix     = p;
    s.check   = k;
    s.first   = f;
    s.fin     = l;
    s.row     = r;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t s;
    s = pix_row('0, CHK_PREDICT, '0, '0, '0);
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic void queue_row(input stim_row_t s);
    directed = {directed, s};
  endfunction

  function automatic void add_expected(input edge_beat_t b);
    pending_edges = {pending_edges, b};
  endfunction

  function automatic logic [PIX_W-1:0] luma(input logic [PIX_W-1:0] r, g, b);
    logic [12:0] acc;
    acc = 13'd11 * r + 13'd16 * g + 13'd5 * b;
    return acc[12:5];
  endfunction

  // Advances the local scanner state by one pixel; returns the number of
  // edge beats that the pixel causes (0 or 2).
  function automatic int scan_pixel(input pixel_t p, output edge_beat_t lead,
                                    output edge_beat_t trail);
    logic [PIX_W-1:0]   gray_hi;
    logic [PIX_W-1:0]   delta;
    logic [CNT_W-1:0]   span;
    int                 n;
    n     = 0;
    lead  = '0;
    trail = '0;
    if (p.frame_start) begin
      row_pos = '0;
      col_pos = '0;
      hits    = '0;
    end
    gray_hi = luma(p.ar, p.ag, p.ab);
    if (luma(p.br, p.bg, p.bb) > gray_hi) gray_hi = luma(p.br, p.bg, p.bb);
    delta = (gray_hi >= p.ar) ? gray_hi - p.ar : p.ar - gray_hi;
    if (delta >= thr_reg) begin
      if (hits == 2'd0) first_col = col_pos;
      last_col = col_pos;
      if (hits < 2'd2) hits = hits + 2'd1;
    end
    if (p.row_end) begin
      span = (last_col >= first_col) ? last_col - first_col : first_col - last_col;
      if (hits == 2'd2 && span >= spacing_reg) begin
        lead  = '{first_col, row_pos, 1'b0, 1'b0};
        trail = '{last_col, row_pos, 1'b1, 1'b1};
        n     = 2;
      end
      hits    = '0;
      col_pos = '0;
      row_pos = (row_pos == CNT_W'(MAX_SIZE - 1)) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = (col_pos == CNT_W'(MAX_SIZE - 1)) ? '0 : col_pos + 1'b1;
    end
    return n;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Edge beats are checked and accepted pixels are predicted at the same edge.
  always @(posedge clk) begin
    edge_beat_t got;
    edge_beat_t want;
    edge_beat_t lead;
    edge_beat_t trail;
    int         n;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{edge_column, edge_row, edge_side, last};
        edge_beats_seen++;
        if (pending_edges.size() == 0) begin
          $error("edge beat with nothing expected: column %0d row %0d side %0d",
                 got.col, got.row, got.side);
          failures++;
        end else begin
          want = pending_edges.pop_front();
          check_field("edge_column", want.col, got.col);
          check_field("edge_row", want.row, got.row);
          check_field("edge_side", want.side, got.side);
          check_field("last", want.is_last, got.is_last);
        end
      end
      if (in_valid && !in_stall) begin
        n = scan_pixel(pixel_t'{a_red, a_green, a_blue, b_red, b_green, b_blue,
                                row_end, frame_start}, lead, trail);
        pixels_taken++;
        case (beat_check)
          CHK_PREDICT: begin
            if (n == 2) begin
              add_expected(lead);
              add_expected(trail);
            end
          end
          CHK_PAIR: begin
            add_expected(edge_beat_t'{typed_first, typed_row, 1'b0, 1'b0});
            add_expected(edge_beat_t'{typed_last, typed_row, 1'b1, 1'b1});
          end
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off when one is asked for.
  initial begin
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        hold_left = 299;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic offer_pixel(input pixel_t p, input check_kind_t k,
                             input logic [COORD_W-1:0] f, l, r);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    a_red       <= p.ar;
    a_green     <= p.ag;
    a_blue      <= p.ab;
    b_red       <= p.br;
    b_green     <= p.bg;
    b_blue      <= p.bb;
    row_end     <= p.row_end;
    frame_start <= p.frame_start;
    beat_check  <= k;
    typed_first <= f;
    typed_last  <= l;
    typed_row   <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Registers change only once the scanner has drained.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_DIFF_THRESHOLD) thr_reg = val[THR_W-1:0];
    else spacing_reg = val[SPACING_W-1:0];
  endtask

  // Mostly well-formed rows of mixed hit and miss pixels, with stray frame
  // starts and early row ends thrown in.
  task automatic send_random_rows(input int count, input int hold_at);
    pixel_t     p;
    int         sent;
    int         len;
    int         kind;
    bit         new_frame;
    logic [7:0] v;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      new_frame = ($urandom_range(0, 7) == 0);
      for (int c = 0; c < len; c++) begin
        kind = $urandom_range(0, 3);
        v    = 8'($urandom_range(0, 255));
        case (kind)
          0: p = mk_pix(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 0);
          1: p = mk_pix(8'($urandom_range(220, 255)), 8'($urandom_range(0, 30)),
                        8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)),
                        8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)), 0, 0);
          2: p = mk_pix(8'($urandom_range(0, 30)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(200, 255)),
                        8'($urandom_range(200, 255)), 8'($urandom_range(200, 255)), 0, 0);
          default: p = mk_pix(v, v, v, v, v, v, 0, 0);
        endcase
        p.row_end     = (c == len - 1) || ($urandom_range(0, 39) == 0);
        p.frame_start = (c == 0 && new_frame) || ($urandom_range(0, 59) == 0);
        if (sent == hold_at) hold_asks++;
        offer_pixel(p, CHK_PREDICT, '0, '0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    int         thr;
    int         sp;

    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    a_red         = '0;
    a_green       = '0;
    a_blue        = '0;
    b_red         = '0;
    b_green       = '0;
    b_blue        = '0;
    row_end       = 1'b0;
    frame_start   = 1'b0;
    beat_check    = CHK_PREDICT;
    typed_first   = '0;
    typed_last    = '0;
    typed_row     = '0;
    thr_reg       = THRESHOLD_RESET;
    spacing_reg   = SPACING_RESET;
    send_idle_pct = 38;
    recv_idle_pct = 80;
    hold_asks     = 0;

    // Reset values: two hits too close together, then a single hit.
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 0, 1), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 0, 0, 0, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 1, 0), CHK_NO_PAIR, 0, 0, 0));
    queue_row(pix_row(mk_pix(255, 0, 0, 0, 0, 0, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 0, 0, 0, 1, 0), CHK_NO_PAIR, 0, 0, 0));
    // Zero threshold and spacing: every pixel is a hit.
    queue_row(cfg_row(REG_DIFF_THRESHOLD, 12'd0));
    queue_row(cfg_row(REG_MIN_SPACING, 12'd0));
    queue_row(pix_row(mk_pix(0, 0, 0, 0, 0, 0, 1, 0), CHK_NO_PAIR, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 0, 0, 0, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(255, 255, 255, 255, 255, 255, 1, 0), CHK_PAIR, 0, 1, 3));
    // Largest threshold and spacing.
    queue_row(cfg_row(REG_DIFF_THRESHOLD, 12'd255));
    queue_row(cfg_row(REG_MIN_SPACING, 12'd4095));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 1, 0), CHK_NO_PAIR, 0, 0, 0));
    // A frame start in mid-row restarts both counters.
    queue_row(cfg_row(REG_MIN_SPACING, 12'd1));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 0, 1), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(255, 255, 255, 0, 0, 0, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 0, 0, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 1, 0), CHK_PAIR, 0, 3, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 1, 1), CHK_NO_PAIR, 0, 0, 0));
    // Three hits saturate the tally; the spacing equals the limit exactly.
    queue_row(cfg_row(REG_DIFF_THRESHOLD, 12'd100));
    queue_row(cfg_row(REG_MIN_SPACING, 12'd3));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(255, 0, 0, 0, 0, 0, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 0, 0, 0, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(0, 0, 0, 255, 255, 255, 1, 0), CHK_PAIR, 0, 3, 1));
    queue_row(pix_row(mk_pix(200, 17, 90, 3, 250, 128, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(170, 85, 60, 40, 10, 220, 0, 0), CHK_PREDICT, 0, 0, 0));
    queue_row(pix_row(mk_pix(1, 254, 128, 127, 2, 253, 1, 0), CHK_PREDICT, 0, 0, 0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_register(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        offer_pixel(directed[i].pix, directed[i].check, directed[i].first,
                    directed[i].fin, directed[i].row);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 80;
          thr = $urandom_range(40, 120);
          sp  = $urandom_range(0, 8);
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 38;
          thr = $urandom_range(120, 220);
          sp  = $urandom_range(0, 20);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          thr = $urandom_range(0, 255);
          sp  = $urandom_range(0, 30);
        end
      endcase
      // Bits above the threshold field are junk and must be dropped.
      write_register(REG_DIFF_THRESHOLD, {4'($urandom_range(0, 15)), 8'(thr)});
      write_register(REG_MIN_SPACING, 12'(sp));
      send_random_rows(200, (ph == 2) ? 40 : -1);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Scanned %0d pixels across zero and full-scale registers, frame restarts,",
             pixels_taken);
    $display("stray row ends and a long output hold-off; %0d edge beats compared.",
             edge_beats_seen);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
